// ===== rtl/scm_pkg.sv =====
// Shared types, sizes and codes of the spectral correlation block.
// Depends on nothing; used by the correlation block, its checker and the testbench.
package scm_pkg;

	localparam int MAX_BINS    = 256;
	localparam int MAX_WINDOWS = 64;
	localparam int BIN_W       = $clog2(MAX_BINS);
	localparam int WIN_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
	localparam int ADDR_W      = BIN_W + WIN_W;
	localparam int DEPTH       = MAX_BINS * (1 << WIN_W);

	localparam logic [1:0] CMD_LOAD_PRI  = 2'd0;
	localparam logic [1:0] CMD_LOAD_CONJ = 2'd1;
	localparam logic [1:0] CMD_QUERY     = 2'd2;

	localparam logic [1:0] REG_NUM_WINDOWS = 2'd0;
	localparam logic [1:0] REG_CONJ_MODE   = 2'd1;
	localparam logic [1:0] REG_SCALE_RECIP = 2'd2;

	localparam logic signed [47:0] POS48 = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] NEG48 = {1'b1, {47{1'b0}}};

	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         window_index;
		logic [7:0]         col_bin;
		logic [7:0]         row_bin;
		logic signed [15:0] value_re;
		logic signed [15:0] value_im;
	} item_t;

	typedef struct packed {
		logic signed [47:0] corr_re;
		logic signed [47:0] corr_im;
		logic [7:0]         entry_col;
		logic [7:0]         entry_row;
	} result_t;

	function automatic logic signed [47:0] sat48_50(input logic signed [49:0] v);
		logic signed [47:0] r;
		if (v > 50'(POS48))
			r = POS48;
		else if (v < $signed({{2{NEG48[47]}}, NEG48}))
			r = NEG48;
		else
			r = v[47:0];
		return r;
	endfunction

endpackage

// ===== rtl/scm_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per beat.
// Payload type is given where the channel is instantiated (scm_pkg structs).
interface scm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spectral_correlation_matrix.sv =====
// Spectral correlation stage: two spectrum stores and a complex MAC sequencer.
// Depends on scm_pkg and scm_stream_if.
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+------------
//  item     | in  | command, window_index, col_bin, row_bin, value | valid/ready
//  result   | out | corr_re, corr_im, entry_col, entry_row         | valid/ready
//  cfg      | in  | cfg_index, cfg_data                            | cfg_we only
//
// A load beat is one store write. A query reads the stores once per window,
// for P = min(num_windows, MAX_WINDOWS) windows, drains the multiply and
// accumulate pipeline, then scales in ST_SCMUL and ST_SCADD; with P = 0 the
// query goes straight to scaling.
// Items are taken only when the sequencer is idle; a result waiting in the
// output register does not block loads, only the end of the next query.
// Stores have no reset and no clearing pass; control resets on arst_n.
module spectral_correlation_matrix (
	input  logic                clk,
	input  logic                arst_n,
	scm_stream_if.sink          item,
	scm_stream_if.source        result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_SCMUL = 5'b01000,
		ST_SCADD = 5'b10000
	} state_t;

	state_t state_q;

	logic [6:0]  num_windows_q;
	logic        conj_mode_q;
	logic [31:0] scale_recip_q;

	logic [31:0] pri_mem  [scm_pkg::DEPTH];
	logic [31:0] conj_mem [scm_pkg::DEPTH];

	logic [7:0]               col_q, row_q;
	logic [scm_pkg::CNT_W-1:0] p_q;
	logic [scm_pkg::WIN_W-1:0] k_q;

	logic [31:0] x_s1, y_s1, c_s1;
	logic        v_s1, last_s1;
	logic signed [31:0] rr_s2, ii_s2, ir_s2, ri_s2;
	logic        v_s2, last_s2;
	logic signed [47:0] acc_re_q, acc_im_q;
	logic signed [64:0] re_hi_q, re_lo_q, im_hi_q, im_lo_q;

	logic               out_valid_q;
	scm_pkg::result_t   out_q;

	logic accept, is_query, last_issue, out_free;
	logic [scm_pkg::ADDR_W-1:0] wr_addr, x_addr, y_addr;
	logic [scm_pkg::CNT_W-1:0]  p_next;
	logic [31:0] wr_word, y_sel;
	logic signed [15:0] ar, ai, br, bi;
	logic signed [49:0] sum_re, sum_im;
	logic signed [80:0] full_re, full_im;
	logic signed [48:0] sh_re, sh_im;
	logic signed [47:0] fin_re, fin_im;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign is_query   = (item.data.command == scm_pkg::CMD_QUERY);
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign p_next = ({25'd0, num_windows_q} > 32'(scm_pkg::MAX_WINDOWS))
		? scm_pkg::CNT_W'(scm_pkg::MAX_WINDOWS)
		: scm_pkg::CNT_W'(num_windows_q);
	assign last_issue = (scm_pkg::CNT_W'(k_q) == p_q - scm_pkg::CNT_W'(1));

	assign wr_addr = {item.data.col_bin[scm_pkg::BIN_W-1:0],
		item.data.window_index[scm_pkg::WIN_W-1:0]};
	assign wr_word = {item.data.value_re, item.data.value_im};
	assign x_addr  = {col_q[scm_pkg::BIN_W-1:0], k_q};
	assign y_addr  = {row_q[scm_pkg::BIN_W-1:0], k_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_windows_q <= 7'd1;
			conj_mode_q   <= 1'b0;
			scale_recip_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scm_pkg::REG_NUM_WINDOWS: num_windows_q <= cfg_data[6:0];
				scm_pkg::REG_CONJ_MODE:   conj_mode_q   <= cfg_data[0];
				scm_pkg::REG_SCALE_RECIP: scale_recip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stores: one write port each, primary read at two addresses
	always_ff @(posedge clk) begin
		if (accept && item.data.command == scm_pkg::CMD_LOAD_PRI)
			pri_mem[wr_addr] <= wr_word;
		x_s1 <= pri_mem[x_addr];
		y_s1 <= pri_mem[y_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && item.data.command == scm_pkg::CMD_LOAD_CONJ)
			conj_mem[wr_addr] <= wr_word;
		c_s1 <= conj_mem[y_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_READ);
			last_s1 <= (state_q == ST_READ) && last_issue;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept && is_query)
						state_q <= (p_next == '0) ? ST_SCMUL : ST_READ;
				end
				ST_READ: begin
					k_q <= k_q + scm_pkg::WIN_W'(1);
					if (last_issue)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2)
						state_q <= ST_SCMUL;
				end
				ST_SCMUL: state_q <= ST_SCADD;
				ST_SCADD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			col_q <= item.data.col_bin;
			row_q <= item.data.row_bin;
			p_q   <= p_next;
		end
	end

	// complex multiply, second operand conjugated
	assign y_sel = conj_mode_q ? c_s1 : y_s1;
	assign ar = $signed(x_s1[31:16]);
	assign ai = $signed(x_s1[15:0]);
	assign br = $signed(y_sel[31:16]);
	assign bi = $signed(y_sel[15:0]);

	always_ff @(posedge clk) begin
		rr_s2 <= ar * br;
		ii_s2 <= ai * bi;
		ir_s2 <= ai * br;
		ri_s2 <= ar * bi;
	end

	assign sum_re = 50'(acc_re_q) + 50'(rr_s2) + 50'(ii_s2);
	assign sum_im = 50'(acc_im_q) + 50'(ir_s2) - 50'(ri_s2);

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s2) begin
			acc_re_q <= scm_pkg::sat48_50(sum_re);
			acc_im_q <= scm_pkg::sat48_50(sum_im);
		end
	end

	// scaling: acc * scale as two 48x16 partial products, then floor >> 32 and saturate to 48 bits
	always_ff @(posedge clk) begin
		if (state_q == ST_SCMUL) begin
			re_hi_q <= acc_re_q * $signed({1'b0, scale_recip_q[31:16]});
			re_lo_q <= acc_re_q * $signed({1'b0, scale_recip_q[15:0]});
			im_hi_q <= acc_im_q * $signed({1'b0, scale_recip_q[31:16]});
			im_lo_q <= acc_im_q * $signed({1'b0, scale_recip_q[15:0]});
		end
	end

	assign full_re = ($signed(81'(re_hi_q)) <<< 16) + 81'(re_lo_q);
	assign full_im = ($signed(81'(im_hi_q)) <<< 16) + 81'(im_lo_q);
	assign sh_re   = full_re[80:32];
	assign sh_im   = full_im[80:32];
	assign fin_re  = (sh_re[48] != sh_re[47]) ? (sh_re[48] ? scm_pkg::NEG48 : scm_pkg::POS48)
		: sh_re[47:0];
	assign fin_im  = (sh_im[48] != sh_im[47]) ? (sh_im[48] ? scm_pkg::NEG48 : scm_pkg::POS48)
		: sh_im[47:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_SCADD && out_free)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCADD && out_free) begin
			out_q.corr_re   <= fin_re;
			out_q.corr_im   <= fin_im;
			out_q.entry_col <= col_q;
			out_q.entry_row <= row_q;
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_pipe_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == ST_READ || state_q == ST_DRAIN))
		else $error("MAC pipeline active outside a query");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (scm_pkg::CNT_W'(k_q) < p_q))
		else $error("window counter ran past the window count");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCADD && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished query did not reach the output register");

	a_no_store_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept)
		else $error("item accepted while a query is in progress");
`endif

endmodule

// ===== test/scm_corr_checker.sv =====
// Scoreboard for the spectral correlation block: mirrors both spectrum stores
// and the registers, predicts each query's entry and checks the result beats.
// Depends on scm_pkg (item_t, result_t, command and register codes).
module scm_corr_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  scm_pkg::item_t    item_data,
	input  logic              result_valid,
	input  logic              result_ready,
	input  scm_pkg::result_t  result_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output int                errors,
	output int                pending,
	output int                matched
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;

	logic [31:0]      pri_spec  [scm_pkg::DEPTH];
	logic [31:0]      conj_spec [scm_pkg::DEPTH];
	logic [6:0]       windows_reg;
	logic             conj_reg;
	logic [31:0]      recip_reg;
	scm_pkg::result_t entry_q [$];
	int               err_cnt;
	int               ok_cnt;

	function automatic longint clamp48(input longint v);
		if (v > ACC_HI)
			return ACC_HI;
		if (v < ACC_LO)
			return ACC_LO;
		return v;
	endfunction

	// floor(acc * recip / 2^32), saturated to 48 bits
	function automatic logic signed [47:0] normalize(input longint acc, input logic [31:0] recip);
		logic signed [80:0] prod;
		prod = 81'(acc) * $signed({1'b0, recip});
		prod = prod >>> 32;
		if (prod > ACC_HI)
			return scm_pkg::POS48;
		if (prod < ACC_LO)
			return scm_pkg::NEG48;
		return prod[47:0];
	endfunction

	function automatic scm_pkg::result_t corr_entry(input logic [7:0] col,
			input logic [7:0] row);
		int               p;
		longint           sum_re, sum_im, ar, ai, br, bi;
		logic [31:0]      x, y;
		scm_pkg::result_t r;
		p = (windows_reg > 7'(scm_pkg::MAX_WINDOWS)) ? scm_pkg::MAX_WINDOWS
			: int'(windows_reg);
		sum_re = 0;
		sum_im = 0;
		for (int k = 0; k < p; k++) begin
			x = pri_spec[{col, scm_pkg::WIN_W'(k)}];
			y = conj_reg ? conj_spec[{row, scm_pkg::WIN_W'(k)}]
				: pri_spec[{row, scm_pkg::WIN_W'(k)}];
			ar = $signed(x[31:16]);
			ai = $signed(x[15:0]);
			br = $signed(y[31:16]);
			bi = $signed(y[15:0]);
			sum_re = clamp48(sum_re + ar * br + ai * bi);
			sum_im = clamp48(sum_im + ai * br - ar * bi);
		end
		r.corr_re   = normalize(sum_re, recip_reg);
		r.corr_im   = normalize(sum_im, recip_reg);
		r.entry_col = col;
		r.entry_row = row;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scm_pkg::result_t want;
		if (!arst_n) begin
			windows_reg = 7'd1;
			conj_reg    = 1'b0;
			recip_reg   = 32'd0;
			entry_q.delete();
			err_cnt     = 0;
			ok_cnt      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					scm_pkg::REG_NUM_WINDOWS: windows_reg = cfg_data[6:0];
					scm_pkg::REG_CONJ_MODE:   conj_reg    = cfg_data[0];
					scm_pkg::REG_SCALE_RECIP: recip_reg   = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				case (item_data.command)
					scm_pkg::CMD_LOAD_PRI:
						pri_spec[{item_data.col_bin, item_data.window_index}] =
							{item_data.value_re, item_data.value_im};
					scm_pkg::CMD_LOAD_CONJ:
						conj_spec[{item_data.col_bin, item_data.window_index}] =
							{item_data.value_re, item_data.value_im};
					scm_pkg::CMD_QUERY:
						entry_q.push_back(corr_entry(item_data.col_bin, item_data.row_bin));
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (entry_q.size() == 0) begin
					$display("%0t: unexpected result beat col %0d row %0d re %0d im %0d",
						$time, result_data.entry_col, result_data.entry_row,
						result_data.corr_re, result_data.corr_im);
					err_cnt++;
				end else begin
					want = entry_q.pop_front();
					if (result_data.corr_re !== want.corr_re) begin
						$display("%0t: corr_re mismatch, expected %0d, got %0d",
							$time, want.corr_re, result_data.corr_re);
						err_cnt++;
					end
					if (result_data.corr_im !== want.corr_im) begin
						$display("%0t: corr_im mismatch, expected %0d, got %0d",
							$time, want.corr_im, result_data.corr_im);
						err_cnt++;
					end
					if (result_data.entry_col !== want.entry_col) begin
						$display("%0t: entry_col mismatch, expected %0d, got %0d",
							$time, want.entry_col, result_data.entry_col);
						err_cnt++;
					end
					if (result_data.entry_row !== want.entry_row) begin
						$display("%0t: entry_row mismatch, expected %0d, got %0d",
							$time, want.entry_row, result_data.entry_row);
						err_cnt++;
					end
					ok_cnt++;
				end
			end
		end
		// published with NBAs so the stimulus side sees settled values
		errors  <= err_cnt;
		pending <= entry_q.size();
		matched <= ok_cnt;
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the spectral correlation testbench: clock, reset, load/query stimulus,
// register phases and the verdict. Depends on scm_pkg, scm_stream_if and
// scm_corr_checker; the DUT is spectral_correlation_matrix.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int PRI_STORE      = 0;
	localparam int CONJ_STORE     = 1;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	scm_stream_if #(.payload_t(scm_pkg::item_t))   item_ch ();
	scm_stream_if #(.payload_t(scm_pkg::result_t)) result_ch ();

	int errors, pending, matched;

	spectral_correlation_matrix u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	scm_corr_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_data    (item_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.matched      (matched)
	);

	// which store entries hold data, and per bin how many windows from 0 are filled
	bit wr_map   [2][scm_pkg::MAX_BINS][scm_pkg::MAX_WINDOWS];
	int fill_len [2][scm_pkg::MAX_BINS];
	int p_eff;
	bit conj_on;
	bit steady;
	bit hold_req;
	bit hold_done;
	int hold_left;
	int quiet;
	int n_loads, n_queries, n_ignored, n_settings;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random stalls, one long hold-off, none while steady
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			result_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			result_ch.ready <= steady || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, quiet);
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic signed [15:0] rand_val();
		case ($urandom_range(9))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int find_bin(input int store);
		int start, b;
		start = $urandom_range(scm_pkg::MAX_BINS - 1);
		for (int i = 0; i < scm_pkg::MAX_BINS; i++) begin
			b = (start + i) % scm_pkg::MAX_BINS;
			if (fill_len[store][b] >= p_eff)
				return b;
		end
		return -1;
	endfunction

	task automatic send_item(input scm_pkg::item_t it);
		if (!steady)
			while ($urandom_range(99) < 21) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
			end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic load_value(input int store, input int bin, input int win,
			input logic signed [15:0] re, input logic signed [15:0] im);
		scm_pkg::item_t it;
		it.command      = (store == CONJ_STORE) ? scm_pkg::CMD_LOAD_CONJ : scm_pkg::CMD_LOAD_PRI;
		it.window_index = 6'(win);
		it.col_bin      = 8'(bin);
		it.row_bin      = 8'($urandom);
		it.value_re     = re;
		it.value_im     = im;
		send_item(it);
		wr_map[store][bin][win] = 1'b1;
		while (fill_len[store][bin] < scm_pkg::MAX_WINDOWS
				&& wr_map[store][bin][fill_len[store][bin]])
			fill_len[store][bin]++;
		n_loads++;
	endtask

	task automatic query_entry(input int col, input int row);
		scm_pkg::item_t it;
		it.command      = scm_pkg::CMD_QUERY;
		it.window_index = 6'($urandom);
		it.col_bin      = 8'(col);
		it.row_bin      = 8'(row);
		it.value_re     = 16'($urandom);
		it.value_im     = 16'($urandom);
		send_item(it);
		n_queries++;
	endtask

	// one spectrum bin over every window a query will walk
	task automatic fill_bin(input int store, input int bin);
		int n;
		n = (p_eff == 0) ? 1 + $urandom_range(3) : p_eff;
		for (int w = 0; w < n; w++)
			load_value(store, bin, w, rand_val(), rand_val());
	endtask

	// wait for the block to drain, then give the sequencer time to go idle
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input int nw, input bit cm, input logic [31:0] recip);
		cfg_we    <= 1'b1;
		cfg_index <= scm_pkg::REG_NUM_WINDOWS;
		cfg_data  <= 32'(nw);
		@(posedge clk);
		cfg_index <= scm_pkg::REG_CONJ_MODE;
		cfg_data  <= 32'(cm);
		@(posedge clk);
		cfg_index <= scm_pkg::REG_SCALE_RECIP;
		cfg_data  <= recip;
		@(posedge clk);
		cfg_we <= 1'b0;
		p_eff   = (nw > scm_pkg::MAX_WINDOWS) ? scm_pkg::MAX_WINDOWS : nw;
		conj_on = cm;
		n_settings++;
	endtask

	task automatic random_step();
		int             pick, col, row, side;
		scm_pkg::item_t it;
		pick = $urandom_range(99);
		side = conj_on ? CONJ_STORE : PRI_STORE;
		if (pick < 4) begin
			it.command      = CMD_UNUSED;
			it.window_index = 6'($urandom);
			it.col_bin      = 8'($urandom);
			it.row_bin      = 8'($urandom);
			it.value_re     = 16'($urandom);
			it.value_im     = 16'($urandom);
			send_item(it);
			n_ignored++;
		end else if (pick < 12) begin
			load_value($urandom_range(1), $urandom_range(scm_pkg::MAX_BINS - 1),
				$urandom_range(scm_pkg::MAX_WINDOWS - 1), rand_val(), rand_val());
		end else if (pick < 30) begin
			if (conj_on ? ($urandom_range(1) == 1) : ($urandom_range(3) == 0))
				fill_bin(CONJ_STORE, $urandom_range(scm_pkg::MAX_BINS - 1));
			else
				fill_bin(PRI_STORE, $urandom_range(scm_pkg::MAX_BINS - 1));
		end else begin
			col = find_bin(PRI_STORE);
			row = find_bin(side);
			if (col < 0)
				fill_bin(PRI_STORE, $urandom_range(scm_pkg::MAX_BINS - 1));
			else if (row < 0)
				fill_bin(side, $urandom_range(scm_pkg::MAX_BINS - 1));
			else
				query_entry(col, row);
		end
	endtask

	task automatic run_phase(input int nw, input bit cm, input logic [31:0] recip, input int count);
		int goal;
		settle();
		apply_settings(nw, cm, recip);
		goal = n_loads + n_queries + count;
		while (n_loads + n_queries < goal)
			random_step();
	endtask

	initial begin
		scm_pkg::item_t junk;
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.data    <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= scm_pkg::REG_NUM_WINDOWS;
		cfg_data        <= '0;
		steady          <= 1'b0;
		hold_req        <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-scale values, both bin extremes, both modes, empty sum
		apply_settings(2, 1'b0, 32'hFFFF_FFFF);
		load_value(PRI_STORE, 0, 0, 16'sh7FFF, 16'sh8000);
		load_value(PRI_STORE, 0, 1, 16'sh8000, 16'sh8000);
		load_value(PRI_STORE, 255, 0, 16'sh8000, 16'sh7FFF);
		load_value(PRI_STORE, 255, 1, 16'sh7FFF, 16'sh7FFF);
		load_value(CONJ_STORE, 0, 0, 16'sh8000, 16'sh8000);
		load_value(CONJ_STORE, 0, 1, 16'sh7FFF, -16'sd1);
		load_value(CONJ_STORE, 255, 0, -16'sd1, 16'sd0);
		load_value(CONJ_STORE, 255, 1, 16'sd0, 16'sh7FFF);
		junk = '1;
		junk.command = CMD_UNUSED;
		send_item(junk);
		n_ignored++;
		query_entry(0, 0);
		query_entry(0, 255);
		query_entry(255, 255);
		query_entry(255, 0);
		settle();
		apply_settings(2, 1'b1, 32'h8000_0000);
		query_entry(0, 255);
		query_entry(255, 0);
		query_entry(0, 0);
		settle();
		apply_settings(0, 1'b0, 32'hFFFF_FFFF);
		query_entry(17, 200);
		query_entry(255, 255);
		load_value(PRI_STORE, 255, 63, 16'sh7FFF, 16'sh8000);

		// random phases; the first one also carries the long result hold-off
		hold_req <= 1'b1;
		run_phase(4, 1'b0, $urandom, 110);
		run_phase(1, 1'b1, 32'hFFFF_FFFF, 90);
		run_phase(0, 1'b0, $urandom, 60);
		run_phase(64, 1'b1, 32'h8000_0000, 160);
		run_phase(127, 1'b0, 32'd1, 60);
		steady <= 1'b1;
		run_phase(7, 1'b1, $urandom, 130);
		steady <= 1'b0;
		run_phase($urandom_range(8, 1), 1'($urandom_range(1)), $urandom, 140);

		settle();
		$display("tb_top: %0d loads, %0d queries, %0d ignored beats over %0d register settings",
			n_loads, n_queries, n_ignored, n_settings);
		$display("tb_top: %0d correlation entries compared", matched);
		if (errors == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
